>>> hdl/gradient_message_parser_unit_assert.svh
// Assertion macros shared by the gradient message parser modules.
`ifndef GRADIENT_MESSAGE_PARSER_UNIT_ASSERT_SVH
`define GRADIENT_MESSAGE_PARSER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define GMP_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define GMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gmp_pkg.sv
// Types and constants of the gradient message parser.
package gmp_pkg;

    localparam int SENDER_BYTES = 16;
    localparam int WORD_BYTES   = 4;
    localparam int COUNT_BYTES  = 2;
    localparam int HEADER_BYTES = SENDER_BYTES + 1 + WORD_BYTES + WORD_BYTES + COUNT_BYTES;
    localparam int HOP_POS      = SENDER_BYTES;
    localparam int SAMPLE_POS   = HOP_POS + 1;
    localparam int STAMP_POS    = SAMPLE_POS + WORD_BYTES;
    localparam int COUNT_POS    = HEADER_BYTES - COUNT_BYTES;

    localparam int POS_W = 19;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [15:0] LIMIT_RESET = 16'd1024;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_OVER  = 2'd2,
        ST_TRUNC = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] sender_high;
        logic [63:0] sender_low;
        logic [7:0]  hops_left;
        logic [31:0] samples;
        logic [31:0] stamp_minutes;
        logic [15:0] word_count;
        logic [15:0] word_index;
        logic [31:0] word_bits;
        status_t     status;
        logic        final_res;
    } result_t;

    // One accepted byte produces at most one entry: a first result,
    // optionally followed by an end result that carries only its status.
    typedef struct packed {
        result_t res;
        logic    has_end;
        status_t end_status;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    function automatic result_t end_result(status_t st);
        result_t r;
        r           = '0;
        r.kind      = KIND_END;
        r.status    = st;
        r.final_res = 1'b1;
        return r;
    endfunction

endpackage

>>> hdl/gmp_parser.sv
// Byte-wise header and gradient word assembly with end-of-message status.
`include "gradient_message_parser_unit_assert.svh"

module gmp_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic [7:0]            byte_value,
    input  logic                  last_byte,
    input  logic                  cfg_fire,
    input  logic [15:0]           cfg_data,
    output gmp_pkg::push_t        push
);

    logic [gmp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [63:0] sender_reg [2];
    logic [63:0] sender_next [2];
    logic [7:0]  hop_reg, hop_next;
    logic [31:0] sample_reg, sample_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] asm_reg, asm_next;
    logic [15:0] words_reg, words_next;
    logic        over_reg, over_next;
    logic [15:0] limit_reg;

    logic [1:0]  sample_lane, stamp_lane, word_lane;
    logic        count_lane;
    logic [2:0]  sender_lane;
    logic        word_emit, header_emit;
    logic        past_header;
    gmp_pkg::status_t end_st;
    gmp_pkg::result_t first_res;

    always_comb
    begin
        sample_lane = 2'(pos_reg - gmp_pkg::POS_W'(gmp_pkg::SAMPLE_POS));
        stamp_lane  = 2'(pos_reg - gmp_pkg::POS_W'(gmp_pkg::STAMP_POS));
        count_lane  = 1'(pos_reg - gmp_pkg::POS_W'(gmp_pkg::COUNT_POS));
        word_lane   = 2'(pos_reg - gmp_pkg::POS_W'(gmp_pkg::HEADER_BYTES));
        sender_lane = 3'd7 - pos_reg[2:0];
        past_header = pos_reg >= gmp_pkg::POS_W'(gmp_pkg::HEADER_BYTES);

        pos_next       = pos_reg;
        sender_next[0] = sender_reg[0];
        sender_next[1] = sender_reg[1];
        hop_next       = hop_reg;
        sample_next    = sample_reg;
        stamp_next     = stamp_reg;
        count_next     = count_reg;
        asm_next       = asm_reg;
        words_next     = words_reg;
        over_next      = over_reg;
        word_emit      = 1'b0;
        header_emit    = 1'b0;

        // Each header byte lands in an empty lane, so a lane write matches an OR.
        if (pos_reg < gmp_pkg::POS_W'(gmp_pkg::SENDER_BYTES))
        begin
            sender_next[pos_reg[3]][8*sender_lane +: 8] = byte_value;
        end
        else if (pos_reg == gmp_pkg::POS_W'(gmp_pkg::HOP_POS))
        begin
            hop_next = byte_value;
        end
        else if (pos_reg < gmp_pkg::POS_W'(gmp_pkg::STAMP_POS))
        begin
            sample_next[8*sample_lane +: 8] = byte_value;
        end
        else if (pos_reg < gmp_pkg::POS_W'(gmp_pkg::COUNT_POS))
        begin
            stamp_next[8*stamp_lane +: 8] = byte_value;
        end
        else if (pos_reg < gmp_pkg::POS_W'(gmp_pkg::HEADER_BYTES))
        begin
            count_next[8*count_lane +: 8] = byte_value;
        end
        else if (!over_reg && (words_reg < count_reg))
        begin
            asm_next[8*word_lane +: 8] = byte_value;
            if (word_lane == 2'(gmp_pkg::WORD_BYTES - 1))
            begin
                word_emit  = 1'b1;
                words_next = words_reg + 16'd1;
                asm_next   = '0;
            end
        end

        if (pos_reg == gmp_pkg::POS_W'(gmp_pkg::HEADER_BYTES - 1))
        begin
            header_emit = 1'b1;
            over_next   = count_next > limit_reg;
        end

        if (pos_reg != gmp_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end

        if (pos_reg < gmp_pkg::POS_W'(gmp_pkg::HEADER_BYTES - 1))
        begin
            end_st = gmp_pkg::ST_SHORT;
        end
        else if (over_next)
        begin
            end_st = gmp_pkg::ST_OVER;
        end
        else if (words_next < count_next)
        begin
            end_st = gmp_pkg::ST_TRUNC;
        end
        else
        begin
            end_st = gmp_pkg::ST_OK;
        end

        first_res = '0;
        if (word_emit)
        begin
            first_res.kind       = gmp_pkg::KIND_WORD;
            first_res.word_index = words_reg;
            first_res.word_bits  = {byte_value, asm_reg[23:0]};
        end
        else if (header_emit)
        begin
            first_res.kind          = gmp_pkg::KIND_HEADER;
            first_res.sender_high   = sender_next[0];
            first_res.sender_low    = sender_next[1];
            first_res.hops_left     = hop_next;
            first_res.samples       = sample_next;
            first_res.stamp_minutes = stamp_next;
            first_res.word_count    = count_next;
        end
        else
        begin
            first_res = gmp_pkg::end_result(end_st);
        end

        push.push             = in_fire && (word_emit || header_emit || last_byte);
        push.entry.res        = first_res;
        push.entry.has_end    = last_byte && (word_emit || header_emit);
        push.entry.end_status = end_st;

        if (last_byte)
        begin
            pos_next       = '0;
            sender_next[0] = '0;
            sender_next[1] = '0;
            hop_next       = '0;
            sample_next    = '0;
            stamp_next     = '0;
            count_next     = '0;
            asm_next       = '0;
            words_next     = '0;
            over_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sender_reg[0] <= '0;
            sender_reg[1] <= '0;
            hop_reg       <= '0;
            sample_reg    <= '0;
            stamp_reg     <= '0;
            count_reg     <= '0;
            asm_reg       <= '0;
            words_reg     <= '0;
            over_reg      <= 1'b0;
            limit_reg     <= gmp_pkg::LIMIT_RESET;
        end
        else
        begin
            if (in_fire)
            begin
                pos_reg       <= pos_next;
                sender_reg[0] <= sender_next[0];
                sender_reg[1] <= sender_next[1];
                hop_reg       <= hop_next;
                sample_reg    <= sample_next;
                stamp_reg     <= stamp_next;
                count_reg     <= count_next;
                asm_reg       <= asm_next;
                words_reg     <= words_next;
                over_reg      <= over_next;
            end
            if (cfg_fire)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    `GMP_ASSERT_NEXT(a_last_clears_pos, in_fire && last_byte, pos_reg == '0, "pos not cleared")
    `GMP_ASSERT_NOW(a_over_after_header, !over_reg || past_header, "over flag inside header")
    `GMP_ASSERT_NOW(a_words_in_count, words_reg <= count_reg, "more words than counted")

endmodule

>>> hdl/gmp_out_queue.sv
// Two-entry result queue; an entry may unroll into a result and an end result.
`include "gradient_message_parser_unit_assert.svh"

module gmp_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  gmp_pkg::push_t    push,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output gmp_pkg::result_t  out_res
);

    gmp_pkg::entry_t mem [gmp_pkg::QUEUE_DEPTH];

    logic [gmp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gmp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gmp_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                            sub_reg, sub_next;

    gmp_pkg::entry_t head;
    logic            pop_slot, pop_entry;

    localparam logic [gmp_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        gmp_pkg::QUEUE_PTR_W'(gmp_pkg::QUEUE_DEPTH - 1);
    localparam logic [gmp_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        gmp_pkg::QUEUE_CNT_W'(gmp_pkg::QUEUE_DEPTH);

    always_comb
    begin
        head      = mem[rd_ptr_reg];
        space     = count_reg != CNT_FULL;
        out_valid = count_reg != '0;
        out_res   = sub_reg ? gmp_pkg::end_result(head.end_status) : head.res;
        pop_slot  = out_valid && out_ready;
        pop_entry = pop_slot && (sub_reg || !head.has_end);

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next    = sub_reg;
        count_next  = count_reg;

        if (push.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_slot)
        begin
            sub_next = !pop_entry;
        end
        if (pop_entry)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end

        case ({push.push, pop_entry})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    `GMP_ASSERT_NOW(a_count_bound, count_reg <= CNT_FULL, "queue count beyond depth")
    `GMP_ASSERT_NOW(a_sub_has_end, !sub_reg || (out_valid && head.has_end), "end slot shown without end result")
    `GMP_ASSERT_NEXT(a_push_counts, push.push && !pop_entry, count_reg == $past(count_reg) + 1'b1, "push not counted")

endmodule

>>> hdl/gradient_message_parser_unit.sv
// Gradient message parser: byte stream in, header, gradient word and end results out.
//
// Usage:
//   s_* carries one message byte per item in s_tdata[7:0]; s_tlast marks the last byte.
//   m_* carries one result per item: m_tuser is the kind (header, gradient word, end),
//   m_tlast is set on the end result, m_tdata packs the remaining fields.
//   cfg_valid/cfg_ready/cfg_data write the 16-bit gradient limit (reset 1024);
//   cfg_ready is always high, write only while no message is in flight.
// Timing:
//   A byte is taken every cycle while s_tready is high. Its results are registered in
//   the queue before they show on m_*. A byte that yields both a result and the end
//   result shows them one after the other; all other bytes yield at most one result.
//   Results wait in a two-entry queue; s_tready follows its fill count alone, so bytes
//   are still taken while a result stalls until both entries are held, then it falls.
// Reset:
//   Clears the parser to the start of a message, empties the queue and loads the
//   default limit. After each end result the parser returns to the same start state.
module gradient_message_parser_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [271:0] m_tdata,   // sender_high, sender_low, hops_left, samples,
                                    // stamp_minutes, word_count, word_index, word_bits,
                                    // status, zero pad
    output logic [1:0]   m_tuser,   // result_kind
    output logic         m_tlast,   // final_res
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    gmp_pkg::push_t   push;
    gmp_pkg::result_t res;
    logic             in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    gmp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .byte_value (s_tdata),
        .last_byte  (s_tlast),
        .cfg_fire   (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push)
    );

    gmp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {6'b0, res.status, res.word_bits, res.word_index, res.word_count,
                      res.stamp_minutes, res.samples, res.hops_left,
                      res.sender_low, res.sender_high};
    assign m_tuser = res.kind;
    assign m_tlast = res.final_res;

endmodule
